[sv/plp_pkg.sv]
// ----------------------------------------------------------------------------
// plp_pkg
// Widths, register indexes, shared request/response types and the CORDIC
// angle table for the polyline label point placer.
// ----------------------------------------------------------------------------
package plp_pkg;

   localparam int COORD_W  = 20;   // vertex coordinate, Q3.16 signed
   localparam int DELTA_W  = 21;   // vertex difference, signed
   localparam int MAG_W    = 20;   // magnitude of a difference
   localparam int SQ_W     = 41;   // sum of squares
   localparam int SQR_W    = 42;   // square root working registers
   localparam int ROOT_W   = 21;
   localparam int TILE_W   = 14;
   localparam int CFG_W    = 24;
   localparam int LEN_W    = 26;   // segment length, Q.8 px
   localparam int STEP_W   = 25;   // spacing + text length
   localparam int MUL_W    = 26;   // multiplier operand width
   localparam int PROD_W   = 52;
   localparam int DIV_N_W  = 46;
   localparam int DIV_D_W  = 26;
   localparam int DIV_CNT_W = 6;
   localparam int VAL_W    = 22;   // coordinate on the segment, signed
   localparam int PT_W     = 16;
   localparam int ANG_W    = 16;
   localparam int ZW       = 26;   // CORDIC angle accumulator, Q16 degrees
   localparam int CX_W     = 32;   // CORDIC x/y
   localparam int ATAN_W   = 22;
   localparam int CORDIC_STEPS = 18;
   localparam int CSTEP_W  = 5;
   localparam int NPT_W    = 7;
   localparam int MAX_POINTS = 64;
   localparam int DEG_LIMIT  = 23040;
   localparam int DEG_RIGHT  = 11520;
   localparam int HALF_TURN_Q16 = 180 * 65536;
   localparam int TILE_RESET = 256;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_LABEL_SPACING = 2'd0;
   localparam csr_index_type CSR_TEXT_LENGTH   = 2'd1;
   localparam csr_index_type CSR_TILE_PIXELS   = 2'd2;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic                      start;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } cordic_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ANG_W-1:0] angle;
   } cordic_rsp_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [CSTEP_W-1:0] i);
      logic [ATAN_W-1:0] e;
      case (i)
         5'd0:  e = 22'd2949120;
         5'd1:  e = 22'd1740967;
         5'd2:  e = 22'd919879;
         5'd3:  e = 22'd466945;
         5'd4:  e = 22'd234379;
         5'd5:  e = 22'd117304;
         5'd6:  e = 22'd58666;
         5'd7:  e = 22'd29335;
         5'd8:  e = 22'd14668;
         5'd9:  e = 22'd7334;
         5'd10: e = 22'd3667;
         5'd11: e = 22'd1833;
         5'd12: e = 22'd917;
         5'd13: e = 22'd458;
         5'd14: e = 22'd229;
         5'd15: e = 22'd115;
         5'd16: e = 22'd57;
         5'd17: e = 22'd29;
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

[sv/plp_intf.sv]
// ----------------------------------------------------------------------------
// plp_req_if / plp_rsp_if
// Valid/ready channels carrying polyline vertices in and label points out.
// ----------------------------------------------------------------------------
interface plp_req_if import plp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic                      starts_line;

   modport source (output valid, vertex_x, vertex_y, starts_line, input ready);
   modport sink   (input valid, vertex_x, vertex_y, starts_line, output ready);
endinterface

interface plp_rsp_if import plp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [PT_W-1:0]         point_x;
   logic [PT_W-1:0]         point_y;
   logic signed [ANG_W-1:0] angle_deg;
   logic                    last_of_run;
   logic                    points_dropped;

   modport source (output valid, point_x, point_y, angle_deg, last_of_run,
                   points_dropped, input ready);
   modport sink   (input valid, point_x, point_y, angle_deg, last_of_run,
                   points_dropped, output ready);
endinterface

[sv/plp_divider.sv]
// ----------------------------------------------------------------------------
// plp_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plp_divider import plp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_N_W - 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_N_W-1:0]   num_ff;   // dividend shifts out, quotient shifts in
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   den_ff;
   logic [DIV_D_W:0]     rem_sh;
   logic [DIV_D_W:0]     diff;
   logic                 ge;

   assign rem_sh = {rem_ff, num_ff[DIV_N_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= LAST_CNT;
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= req.num;
         rem_ff <= '0;
         den_ff <= req.den;
      end else if (busy_ff) begin
         num_ff <= {num_ff[DIV_N_W-2:0], ge};
         rem_ff <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;

endmodule

[sv/plp_isqrt.sv]
// ----------------------------------------------------------------------------
// plp_isqrt
// Integer square root (floor), one result bit per cycle.
// ----------------------------------------------------------------------------
module plp_isqrt import plp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);

   localparam logic [SQR_W-1:0] TOP_BIT = SQR_W'(1) << (2 * (ROOT_W - 1));

   logic             busy_ff;
   logic             done_ff;
   logic [SQR_W-1:0] n_ff;
   logic [SQR_W-1:0] r_ff;
   logic [SQR_W-1:0] bit_ff;
   logic [SQR_W-1:0] rb;
   logic             ge;

   assign rb = r_ff + bit_ff;
   assign ge = n_ff >= rb;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         n_ff   <= {1'b0, req.radicand};
         r_ff   <= '0;
         bit_ff <= TOP_BIT;
      end else if (busy_ff) begin
         if (ge) begin
            n_ff <= n_ff - rb;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = r_ff[ROOT_W-1:0];

endmodule

[sv/plp_cordic.sv]
// ----------------------------------------------------------------------------
// plp_cordic
// Vectoring CORDIC: segment angle atan2(-dy, dx) in degrees, Q8.7.
// ----------------------------------------------------------------------------
module plp_cordic import plp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);

   localparam logic [CSTEP_W-1:0] LAST_STEP = CSTEP_W'(CORDIC_STEPS - 1);
   localparam logic signed [ZW-1:0] HALF_TURN = ZW'(HALF_TURN_Q16);
   localparam logic [ZW-1:0] ROUND_HALF = ZW'(256);
   localparam logic [ZW-10:0] LIMIT_MAG = (ZW-9)'(DEG_LIMIT);

   logic                    busy_ff;
   logic                    round_ff;
   logic                    done_ff;
   logic [CSTEP_W-1:0]      idx_ff;
   logic signed [CX_W-1:0]  x_ff;
   logic signed [CX_W-1:0]  y_ff;
   logic signed [ZW-1:0]    z_ff;
   logic signed [ANG_W-1:0] angle_ff;

   logic signed [CX_W-1:0]  x0, y0, xs, ys;
   logic signed [ZW-1:0]    at;
   logic [ZW-1:0]           zmag, zsum;
   logic [ZW-10:0]          mag, magc;
   logic [ANG_W-1:0]        mag16;

   // arithmetic shift that truncates toward zero
   function automatic logic signed [CX_W-1:0] tshift(input logic signed [CX_W-1:0] v,
                                                     input logic [CSTEP_W-1:0] s);
      logic signed [CX_W-1:0] r;
      if (v[CX_W-1])
         r = -((-v) >>> s);
      else
         r = v >>> s;
      return r;
   endfunction

   assign x0 = {{(CX_W-DELTA_W-8){req.dx[DELTA_W-1]}}, req.dx, 8'b0};
   assign y0 = -{{(CX_W-DELTA_W-8){req.dy[DELTA_W-1]}}, req.dy, 8'b0};
   assign xs = tshift(x_ff, idx_ff);
   assign ys = tshift(y_ff, idx_ff);
   assign at = {{(ZW-ATAN_W){1'b0}}, atan_entry(idx_ff)};

   assign zmag  = z_ff[ZW-1] ? -z_ff : z_ff;
   assign zsum  = zmag + ROUND_HALF;
   assign mag   = zsum[ZW-1:9];
   assign magc  = (mag > LIMIT_MAG) ? LIMIT_MAG : mag;
   assign mag16 = ANG_W'(magc);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff  <= 1'b0;
         round_ff <= 1'b0;
         if (req.start) begin
            if (req.dy == '0 || req.dx == '0)
               done_ff <= 1'b1;
            else
               busy_ff <= 1'b1;
         end else if (busy_ff && idx_ff == LAST_STEP) begin
            busy_ff  <= 1'b0;
            round_ff <= 1'b1;
         end else if (round_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         idx_ff <= '0;
         if (req.dy == '0)
            angle_ff <= req.dx[DELTA_W-1] ? -ANG_W'(DEG_LIMIT) : '0;
         else if (req.dx == '0)
            angle_ff <= req.dy[DELTA_W-1] ? ANG_W'(DEG_RIGHT) : -ANG_W'(DEG_RIGHT);
         if (req.dx[DELTA_W-1]) begin
            x_ff <= -x0;
            y_ff <= -y0;
            z_ff <= req.dy[DELTA_W-1] ? HALF_TURN : -HALF_TURN;
         end else begin
            x_ff <= x0;
            y_ff <= y0;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         idx_ff <= idx_ff + 1'b1;
         if (!y_ff[CX_W-1] && y_ff != '0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end
      end else if (round_ff) begin
         angle_ff <= z_ff[ZW-1] ? -mag16 : mag16;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.angle = angle_ff;

endmodule

[sv/polyline_label_point_placer.sv]
// ----------------------------------------------------------------------------
// polyline_label_point_placer
// Places label points along polyline segments, one vertex per request.
//
// req_chan takes one vertex per transfer; starts_line (or the first vertex
// after reset) opens a new line and finishes in the idle state with no points.
// Every other vertex closes a segment from the previous vertex and yields
// zero to 64 points on rsp_chan, each held until its transfer completes;
// last_of_run marks the final point of the segment. req_chan is not ready
// until all points of the current segment are delivered.
// Per segment: the length from a 21-step square root, then the point count
// division, then a binary search for the points inside the tile: four
// bounds of up to log2(count) + 1 probes, then the angle, and per point two
// coordinate passes and the output transfer. Probes, the point count and
// the coordinate passes all use the one shared divider. A stalled rsp_chan
// holds the block in place; nothing is lost.
// Reset (synchronous) clears the line state and the registers: spacing 0,
// text length 0, tile size 256. Idle csr writes apply to the next segment.
// ----------------------------------------------------------------------------
module polyline_label_point_placer import plp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   plp_req_if.sink            req_chan,
   plp_rsp_if.source          rsp_chan,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [CFG_W-1:0]   csr_wdata
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_SQX    = 14'b00000000000010,
      ST_SQY    = 14'b00000000000100,
      ST_SUM    = 14'b00000000001000,
      ST_ROOT   = 14'b00000000010000,
      ST_LEN    = 14'b00000000100000,
      ST_P0     = 14'b00000001000000,
      ST_KDIV   = 14'b00000010000000,
      ST_RUN    = 14'b00000100000000,
      ST_BOUND  = 14'b00001000000000,
      ST_CMUL   = 14'b00010000000000,
      ST_CPOS   = 14'b00100000000000,
      ST_CDIV   = 14'b01000000000000,
      ST_OUT    = 14'b10000000000000
   } state_type;

   localparam logic [LEN_W-1:0] MAX_PTS = LEN_W'(MAX_POINTS);

   state_type state_ff, state_in;

   // configuration
   logic [CFG_W-1:0]  spacing_ff, text_ff;
   logic [TILE_W-1:0] tile_ff;

   // line state
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic                      have_prev_ff, first_seg_ff;
   logic [STEP_W-1:0]         run_ff;

   // segment
   logic signed [COORD_W-1:0] sx_ff, sy_ff;
   logic signed [DELTA_W-1:0] dx_ff, dy_ff;
   logic [SQ_W-1:0]           acc_ff;
   logic [PROD_W-1:0]         mul_ff;
   logic [LEN_W-1:0]          len_ff, p0_ff, kcount_ff;
   logic [STEP_W-1:0]         step_ff;
   logic                      mid_ff;

   // search and emit
   logic [1:0]         bound_ff;
   logic [LEN_W-1:0]   lo_ff, hi_ff, klo_ff, khi_ff, idx_ff;
   logic               emit_ff, axis_ff, pending_ff;
   logic [NPT_W-1:0]   k_ff, n_ff;
   logic               dropped_ff;
   logic signed [ANG_W-1:0] angle_ff;
   logic [PT_W-1:0]    px_ff, py_ff;

   div_req_type    div_req;
   div_rsp_type    div_rsp;
   sqrt_req_type   sqrt_req;
   sqrt_rsp_type   sqrt_rsp;
   cordic_req_type cor_req;
   cordic_rsp_type cor_rsp;

   logic [MUL_W-1:0]          mul_a, mul_b;
   logic [MAG_W-1:0]          adx, ady, ad_axis;
   logic signed [DELTA_W-1:0] d_axis, d_bound;
   logic signed [COORD_W-1:0] s_axis;
   logic [LEN_W-1:0]          pos, min_ls, p0_c, mid_idx, cnt;
   logic [LEN_W:0]            lohi;
   logic [LEN_W:0]            run_sum;
   logic signed [VAL_W-1:0]   v;
   logic [MAG_W-1:0]          q;
   logic                      h, rising, go_hi;
   logic                      req_xfer, rsp_xfer, new_line;

   plp_divider u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   plp_isqrt   u_sqrt (.clock(clock), .reset(reset), .req(sqrt_req), .rsp(sqrt_rsp));
   plp_cordic  u_cordic (.clock(clock), .reset(reset), .req(cor_req), .rsp(cor_rsp));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (state_ff == ST_OUT);
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign new_line = req_chan.starts_line || !have_prev_ff;

   assign rsp_chan.point_x        = px_ff;
   assign rsp_chan.point_y        = py_ff;
   assign rsp_chan.angle_deg      = angle_ff;
   assign rsp_chan.last_of_run    = (k_ff + 1'b1) == n_ff;
   assign rsp_chan.points_dropped = dropped_ff;

   assign adx     = dx_ff[DELTA_W-1] ? MAG_W'(-dx_ff) : MAG_W'(dx_ff);
   assign ady     = dy_ff[DELTA_W-1] ? MAG_W'(-dy_ff) : MAG_W'(dy_ff);
   assign d_axis  = axis_ff ? dy_ff : dx_ff;
   assign ad_axis = axis_ff ? ady : adx;
   assign s_axis  = axis_ff ? sy_ff : sx_ff;
   assign d_bound = bound_ff[1] ? dy_ff : dx_ff;

   assign pos     = p0_ff + mul_ff[LEN_W-1:0];
   assign min_ls  = (len_ff < LEN_W'(spacing_ff)) ? len_ff : LEN_W'(spacing_ff);
   assign p0_c    = mid_ff ? (len_ff >> 1) :
                    first_seg_ff ? (min_ls >> 1) : LEN_W'(run_ff);
   assign lohi    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_idx = lohi[LEN_W:1];
   assign run_sum = {1'b0, p0_ff} + mul_ff[LEN_W:0] - {1'b0, len_ff};
   assign cnt     = (khi_ff > klo_ff) ? khi_ff - klo_ff : '0;

   // point on the segment for the current axis
   assign q = div_rsp.quot[MAG_W-1:0];
   assign v = d_axis[DELTA_W-1] ?
              {{(VAL_W-COORD_W){s_axis[COORD_W-1]}}, s_axis} - VAL_W'(q) :
              {{(VAL_W-COORD_W){s_axis[COORD_W-1]}}, s_axis} + VAL_W'(q);
   // lower bound: v > 0; upper bound: v < 1.0
   assign h      = bound_ff[0] ? (v[VAL_W-1] || v[VAL_W-2:PT_W] == '0)
                               : (!v[VAL_W-1] && v != '0);
   assign rising = (d_bound[DELTA_W-1] == bound_ff[0]);
   assign go_hi  = rising ? h : !h;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX: begin
            mul_a = MUL_W'(adx);
            mul_b = MUL_W'(adx);
         end
         ST_SQY: begin
            mul_a = MUL_W'(ady);
            mul_b = MUL_W'(ady);
         end
         ST_ROOT: begin
            mul_a = MUL_W'(sqrt_rsp.root);
            mul_b = MUL_W'(tile_ff);
         end
         ST_KDIV: begin
            mul_a = div_rsp.quot[MUL_W-1:0];
            mul_b = MUL_W'(step_ff);
         end
         ST_CMUL: begin
            mul_a = idx_ff;
            mul_b = MUL_W'(step_ff);
         end
         ST_CPOS: begin
            mul_a = MUL_W'(ad_axis);
            mul_b = pos;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      sqrt_req.start    = (state_ff == ST_SUM);
      sqrt_req.radicand = acc_ff + mul_ff[SQ_W-1:0];

      div_req.start = 1'b0;
      div_req.num   = DIV_N_W'(len_ff) - DIV_N_W'(p0_c) + DIV_N_W'(step_ff) - DIV_N_W'(1);
      div_req.den   = DIV_D_W'(step_ff);
      if (state_ff == ST_P0) begin
         div_req.start = !mid_ff && (p0_c < len_ff);
      end else if (state_ff == ST_CPOS) begin
         // once pending clears, the distance product is in mul_ff
         div_req.start = !pending_ff;
         div_req.num   = mul_ff[DIV_N_W-1:0];
         div_req.den   = len_ff;
      end

      cor_req.start = (state_ff == ST_BOUND) && (lo_ff >= hi_ff) && (bound_ff == 2'd3);
      cor_req.dx    = dx_ff;
      cor_req.dy    = dy_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_xfer && !new_line) state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ROOT;
         ST_ROOT:  if (sqrt_rsp.done) state_in = ST_LEN;
         ST_LEN:   state_in = ST_P0;
         ST_P0: begin
            if (p0_c >= len_ff) state_in = ST_IDLE;
            else if (mid_ff)    state_in = ST_BOUND;
            else                state_in = ST_KDIV;
         end
         ST_KDIV:  if (div_rsp.done) state_in = ST_RUN;
         ST_RUN:   state_in = ST_BOUND;
         ST_BOUND: begin
            if (lo_ff < hi_ff)
               state_in = ST_CMUL;
            else if (bound_ff == 2'd3)
               state_in = ST_CDIV;   // waits there for the angle
         end
         ST_CMUL:  state_in = ST_CPOS;
         ST_CPOS:  if (!pending_ff) state_in = ST_CDIV;
         ST_CDIV: begin
            if (emit_ff) begin
               if (div_rsp.done) state_in = axis_ff ? ST_OUT : ST_CMUL;
            end else if (pending_ff && cnt == '0) begin
               // points counted: stop if none lie inside
               state_in = ST_IDLE;
            end else if (cor_rsp.done) begin
               state_in = ST_CMUL;
            end else if (div_rsp.done) begin
               state_in = ST_BOUND;
            end
         end
         ST_OUT:   if (rsp_xfer) state_in = ((k_ff + 1'b1) == n_ff) ? ST_IDLE : ST_CMUL;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spacing_ff   <= '0;
         text_ff      <= '0;
         tile_ff      <= TILE_W'(TILE_RESET);
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         first_seg_ff <= 1'b1;
         run_ff       <= '0;
         emit_ff      <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LABEL_SPACING: spacing_ff <= csr_wdata;
               CSR_TEXT_LENGTH:   text_ff    <= csr_wdata;
               CSR_TILE_PIXELS:   tile_ff    <= csr_wdata[TILE_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  prev_x_ff    <= req_chan.vertex_x;
                  prev_y_ff    <= req_chan.vertex_y;
                  have_prev_ff <= 1'b1;
                  emit_ff      <= 1'b0;
                  if (new_line) begin
                     first_seg_ff <= 1'b1;
                     run_ff       <= '0;
                  end
               end
            end
            ST_P0: begin
               first_seg_ff <= 1'b0;
               if (p0_c >= len_ff)
                  run_ff <= mid_ff ? '0 : STEP_W'(p0_c - len_ff);
               else if (mid_ff)
                  run_ff <= '0;
            end
            ST_RUN: run_ff <= run_sum[STEP_W-1:0];
            ST_BOUND: begin
               // pending marks the count check after the last bound
               if (lo_ff >= hi_ff && bound_ff == 2'd3) pending_ff <= 1'b1;
            end
            ST_CMUL: pending_ff <= 1'b1;
            ST_CPOS: pending_ff <= 1'b0;
            ST_CDIV: begin
               if (!emit_ff && pending_ff && cnt == '0) begin
                  pending_ff <= 1'b0;
               end else if (!emit_ff && cor_rsp.done) begin
                  emit_ff    <= 1'b1;
                  pending_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            sx_ff <= prev_x_ff;
            sy_ff <= prev_y_ff;
            dx_ff <= DELTA_W'(req_chan.vertex_x) - DELTA_W'(prev_x_ff);
            dy_ff <= DELTA_W'(req_chan.vertex_y) - DELTA_W'(prev_y_ff);
         end
         ST_SQY: acc_ff <= mul_ff[SQ_W-1:0];
         ST_LEN: begin
            len_ff  <= mul_ff[LEN_W+7:8];
            step_ff <= STEP_W'(spacing_ff) + STEP_W'(text_ff);
            mid_ff  <= (spacing_ff == '0);
         end
         ST_P0: begin
            p0_ff     <= p0_c;
            kcount_ff <= LEN_W'(1);
            bound_ff  <= '0;
            lo_ff     <= '0;
            hi_ff     <= LEN_W'(1);
            klo_ff    <= '0;
            khi_ff    <= LEN_W'(1);
         end
         ST_KDIV: begin
            if (div_rsp.done) begin
               kcount_ff <= div_rsp.quot[LEN_W-1:0];
               hi_ff     <= div_rsp.quot[LEN_W-1:0];
               khi_ff    <= div_rsp.quot[LEN_W-1:0];
            end
         end
         ST_BOUND: begin
            if (lo_ff < hi_ff) begin
               idx_ff  <= mid_idx;
               axis_ff <= bound_ff[1];
            end else begin
               if (rising) begin
                  if (lo_ff > klo_ff) klo_ff <= lo_ff;
               end else begin
                  if (lo_ff < khi_ff) khi_ff <= lo_ff;
               end
               if (bound_ff != 2'd3) begin
                  bound_ff <= bound_ff + 1'b1;
                  lo_ff    <= '0;
                  hi_ff    <= kcount_ff;
               end
            end
         end
         ST_CDIV: begin
            if (emit_ff) begin
               if (div_rsp.done) begin
                  if (axis_ff) begin
                     py_ff <= v[PT_W-1:0];
                  end else begin
                     px_ff   <= v[PT_W-1:0];
                     axis_ff <= 1'b1;
                  end
               end
            end else begin
               // exact angles can finish in the first wait cycle
               if (pending_ff) begin
                  dropped_ff <= cnt > MAX_PTS;
                  n_ff       <= (cnt > MAX_PTS) ? NPT_W'(MAX_POINTS) : cnt[NPT_W-1:0];
               end
               if (cor_rsp.done) begin
                  angle_ff <= cor_rsp.angle;
                  idx_ff   <= klo_ff;
                  axis_ff  <= 1'b0;
                  k_ff     <= '0;
               end else if (div_rsp.done) begin
                  if (go_hi) hi_ff <= idx_ff;
                  else       lo_ff <= idx_ff + 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               k_ff    <= k_ff + 1'b1;
               idx_ff  <= idx_ff + 1'b1;
               axis_ff <= 1'b0;
            end
         end
         default: ;
      endcase
   end

endmodule

[test/polyline_label_point_placer_tb.sv]
// ----------------------------------------------------------------------------
// polyline_label_point_placer_tb
// Feeds polylines through the label point placer and checks every placed
// point against a bit-true predictor kept in a small scoreboard class.
// Register settings change between phases, while the block is idle.
// ----------------------------------------------------------------------------
module polyline_label_point_placer_tb;
   import plp_pkg::*;

   localparam int CLK_HALF   = 6;
   localparam int DRAIN_WAIT = 6000;   // covers the slowest segment with no points
   localparam int LONG_HOLD  = 2500;
   localparam int RUN_LIMIT  = 20_000_000;
   localparam longint ONE_TILE = 65536;
   localparam int ATAN_Q16 [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
      7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

   typedef struct {
      bit [PT_W-1:0]         px;
      bit [PT_W-1:0]         py;
      bit signed [ANG_W-1:0] ang;
      bit                    last;
      bit                    dropped;
   } label_point_type;

   class label_point_board;
      longint spacing, text_len, tile;
      longint prev_x, prev_y;
      bit     have_prev, first_seg;
      bit [31:0] run_pos;
      longint seg_s [2], seg_d [2];
      longint p0, step, len;
      label_point_type expected_points [$];
      int points_checked;

      function new();
         spacing = 0; text_len = 0; tile = TILE_RESET;
         prev_x = 0; prev_y = 0; have_prev = 0; first_seg = 1; run_pos = 0;
         points_checked = 0;
      endfunction

      function void write_reg(csr_index_type idx, longint val);
         case (idx)
            CSR_LABEL_SPACING: spacing = val & 24'hFFFFFF;
            CSR_TEXT_LENGTH:   text_len = val & 24'hFFFFFF;
            CSR_TILE_PIXELS:   tile = val & 14'h3FFF;
            default: ;
         endcase
      endfunction

      function longint root_floor(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      function longint trunc_shift(longint v, int s);
         return v >= 0 ? (v >>> s) : -((-v) >>> s);
      endfunction

      function longint heading(longint dx, longint dy);
         longint x, y, z, xs, ys, mag, q;
         if (dy == 0) return dx < 0 ? -DEG_LIMIT : 0;
         if (dx == 0) return dy < 0 ? DEG_RIGHT : -DEG_RIGHT;
         x = dx * 256;
         y = -dy * 256;
         z = 0;
         if (x < 0) begin
            z = (dy < 0 ? 180 : -180) * ONE_TILE;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y > 0) begin
               x += ys; y -= xs; z += ATAN_Q16[i];
            end else begin
               x -= ys; y += xs; z -= ATAN_Q16[i];
            end
         end
         mag = z < 0 ? -z : z;
         mag = (mag + 256) >>> 9;
         q = z < 0 ? -mag : mag;
         if (q > DEG_LIMIT) q = DEG_LIMIT;
         if (q < -DEG_LIMIT) q = -DEG_LIMIT;
         return q;
      endfunction

      function longint coord(int axis, longint pos);
         longint d, m;
         d = seg_d[axis];
         m = ((d < 0 ? -d : d) * pos) / len;
         return d < 0 ? seg_s[axis] - m : seg_s[axis] + m;
      endfunction

      // even c: lower bound (> 0), odd c: upper bound (< one tile)
      function bit bound_ok(int c, longint k);
         longint v;
         v = coord(c >> 1, p0 + k * step);
         return (c & 1) ? (v < ONE_TILE) : (v > 0);
      endfunction

      function void accept_vertex(longint x, longint y, bit starts);
         longint adx, ady, kcount, klo, khi, lo, hi, m, cnt, n, ang, pos;
         bit mid, dropped, rising, h;
         label_point_type p;
         if (starts || !have_prev) begin
            prev_x = x; prev_y = y;
            have_prev = 1; first_seg = 1; run_pos = 0;
            return;
         end
         seg_s[0] = prev_x; seg_s[1] = prev_y;
         seg_d[0] = x - prev_x; seg_d[1] = y - prev_y;
         prev_x = x; prev_y = y;
         adx = seg_d[0] < 0 ? -seg_d[0] : seg_d[0];
         ady = seg_d[1] < 0 ? -seg_d[1] : seg_d[1];
         len = (root_floor(adx * adx + ady * ady) * tile) >>> 8;
         mid = (spacing == 0);
         step = mid ? 0 : spacing + text_len;
         if (mid) p0 = len / 2;
         else if (first_seg) p0 = (len < spacing ? len : spacing) / 2;
         else p0 = run_pos;
         if (p0 >= len) kcount = 0;
         else if (mid) kcount = 1;
         else kcount = (len - p0 + step - 1) / step;
         run_pos = mid ? 0 : 32'(p0 + kcount * step - len);
         first_seg = 0;
         if (kcount == 0) return;
         klo = 0;
         khi = kcount;
         for (int c = 0; c < 4; c++) begin
            rising = (seg_d[c >> 1] >= 0) == ((c & 1) == 0);
            lo = 0;
            hi = kcount;
            while (lo < hi) begin
               m = lo + (hi - lo) / 2;
               h = bound_ok(c, m);
               if (rising ? h : !h) hi = m;
               else lo = m + 1;
            end
            if (rising) begin
               if (lo > klo) klo = lo;
            end else if (lo < khi) khi = lo;
         end
         cnt = khi > klo ? khi - klo : 0;
         if (cnt == 0) return;
         dropped = cnt > MAX_POINTS;
         n = dropped ? MAX_POINTS : cnt;
         ang = heading(seg_d[0], seg_d[1]);
         for (longint k = 0; k < n; k++) begin
            pos = p0 + (klo + k) * step;
            p.px = PT_W'(coord(0, pos));
            p.py = PT_W'(coord(1, pos));
            p.ang = ANG_W'(ang);
            p.last = (k + 1 == n);
            p.dropped = dropped;
            expected_points = {expected_points, p};
         end
      endfunction

      function bit compare_point(label_point_type got, output string msg);
         label_point_type e;
         if (expected_points.size() == 0) begin
            msg = $sformatf("unexpected point x=%0d y=%0d", got.px, got.py);
            return 0;
         end
         e = expected_points.pop_front();
         points_checked++;
         msg = "";
         if (got.px != e.px) msg = {msg, $sformatf(" point_x %0d/%0d", got.px, e.px)};
         if (got.py != e.py) msg = {msg, $sformatf(" point_y %0d/%0d", got.py, e.py)};
         if (got.ang != e.ang) msg = {msg, $sformatf(" angle %0d/%0d", got.ang, e.ang)};
         if (got.last != e.last) msg = {msg, $sformatf(" last %0d/%0d", got.last, e.last)};
         if (got.dropped != e.dropped)
            msg = {msg, $sformatf(" dropped %0d/%0d", got.dropped, e.dropped)};
         if (msg != "") begin
            msg = {$sformatf("point %0d got/exp:", points_checked), msg};
            return 0;
         end
         return 1;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CFG_W-1:0]    csr_wdata;

   plp_req_if req_chan ();
   plp_rsp_if rsp_chan ();

   polyline_label_point_placer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   label_point_board board;
   int  mismatches;
   int  vertices_sent;
   int  line_len;
   bit  idle_on;
   bit  hold_request;

   initial begin
      clock = 0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      #(2 * CLK_HALF * RUN_LIMIT);
      $display("tb: timeout");
      $display("tb: failure");
      $finish;
   end

   task automatic report(string msg);
      mismatches++;
      $display("tb: mismatch: %s", msg);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.write_reg(idx, val);
   endtask

   task automatic set_regs(logic [CFG_W-1:0] spc, logic [CFG_W-1:0] txt,
                           logic [CFG_W-1:0] tl);
      write_csr(CSR_LABEL_SPACING, spc);
      write_csr(CSR_TEXT_LENGTH, txt);
      write_csr(CSR_TILE_PIXELS, tl);
   endtask

   task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic starts);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.vertex_x    <= x;
      req_chan.vertex_y    <= y;
      req_chan.starts_line <= starts;
      do @(posedge clock); while (!req_chan.ready);
      board.accept_vertex(longint'(x), longint'(y), starts);
      vertices_sent++;
   endtask

   // sender waits for every point, then lets the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      if ($urandom_range(0, 7) == 0) return COORD_W'($urandom);
      return COORD_W'($urandom_range(0, 98303) - 16384);
   endfunction

   task automatic random_vertices(int count);
      logic starts;
      for (int i = 0; i < count; i++) begin
         // lines carry across phases, so register changes land mid-line too
         starts = (line_len == 0) || ($urandom_range(0, 11) == 0);
         line_len = starts ? $urandom_range(2, 8) : line_len;
         send_vertex(pick_coord(), pick_coord(), starts);
         line_len--;
      end
   endtask

   // receiver
   initial begin
      label_point_type got;
      string msg;
      int n;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            n = LONG_HOLD;
         end else n = idle_on ? $urandom_range(0, 15) : 0;
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.px      = rsp_chan.point_x;
         got.py      = rsp_chan.point_y;
         got.ang     = rsp_chan.angle_deg;
         got.last    = rsp_chan.last_of_run;
         got.dropped = rsp_chan.points_dropped;
         if (!board.compare_point(got, msg)) report(msg);
      end
   end

   initial begin
      board = new();
      mismatches = 0;
      vertices_sent = 0;
      line_len = 0;
      idle_on = 1;
      hold_request = 0;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_LABEL_SPACING;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.vertex_x    <= '0;
      req_chan.vertex_y    <= '0;
      req_chan.starts_line <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // midpoint mode at reset values: first vertex without a start flag,
      // exact angles, zero length, extreme coordinates, one-unit segment
      send_vertex(16384, 32768, 0);
      send_vertex(49152, 32768, 0);
      send_vertex(16384, 32768, 0);
      send_vertex(16384, 0, 0);
      send_vertex(16384, 60000, 0);
      send_vertex(50000, 10000, 0);
      send_vertex(50000, 10000, 0);
      send_vertex(-524288, -524288, 1);
      send_vertex(524287, 524287, 0);
      send_vertex(524287, -524288, 0);
      send_vertex(-524288, 524287, 0);
      send_vertex(30000, 40000, 1);
      send_vertex(30001, 40000, 0);
      send_vertex(1, 65535, 0);
      drain();

      // dense spacing on a big tile: point limit
      set_regs(1, 0, 8192);
      send_vertex(1, 1, 1);
      send_vertex(65535, 65535, 0);
      send_vertex(0, 32768, 1);
      send_vertex(65535, 32768, 0);
      send_vertex(-30000, 32768, 0);
      drain();

      // ordinary spacing, with one long receiver stall mid-phase
      set_regs(40 * 256, 20 * 256, 256);
      random_vertices(50);
      hold_request = 1;
      random_vertices(30);
      idle_on = 0;
      random_vertices(30);
      idle_on = 1;
      drain();

      set_regs(24'hFFFFFF, 24'hFFFFFF, 1);
      random_vertices(25);
      drain();

      set_regs(0, CFG_W'($urandom_range(0, 24'hFFFFFF)), 0);
      random_vertices(15);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         set_regs(CFG_W'($urandom_range(10 * 256, 80 * 256)),
                  CFG_W'($urandom_range(0, 40 * 256)),
                  CFG_W'($urandom_range(64, 512)));
         random_vertices(45);
         drain();
      end

      $display("tb: %0d vertices sent, %0d label points checked over 9 register settings",
               vertices_sent, board.points_checked);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
